>>> sv/hnm_pkg.sv
package hnm_pkg;

    // Field widths of the host-side items.
    localparam int NODE_FW  = 12;
    localparam int SYM_W    = 6;
    localparam int PID_W    = 10;
    localparam int CHAR_W   = 8;
    localparam int CNT_W    = 10;

    localparam int NODES_DEF = 4096;
    localparam int ALPHABET  = 38;
    localparam int PATTERNS  = 1023;

    localparam logic [SYM_W-1:0] SYM_DOT    = SYM_W'(10 + 26);
    localparam logic [SYM_W-1:0] SYM_HYPHEN = SYM_W'(10 + 26 + 1);
    localparam logic [SYM_W-1:0] SYM_NONE   = SYM_W'(10 + 26 + 2);

    localparam logic [CNT_W-1:0] MAX_CHARS_RESET = CNT_W'(255);

    typedef enum logic [1:0] {
        FUNC_CHILD = 2'd0,
        FUNC_NODE  = 2'd1,
        FUNC_CHAR  = 2'd2,
        FUNC_NOP   = 2'd3
    } func_t;

    typedef struct packed {
        logic [1:0]         func;
        logic [NODE_FW-1:0] node;
        logic [SYM_W-1:0]   symbol;
        logic [NODE_FW-1:0] child_node;
        logic [NODE_FW-1:0] fail_node;
        logic [PID_W-1:0]   pattern_id;
        logic [CHAR_W-1:0]  char_code;
        logic               last;
    } hnm_in_t;

    typedef struct packed {
        logic             blocked;
        logic [PID_W-1:0] hit_pattern;
        logic             bad_char;
    } hnm_out_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_LOOKUP,
        ST_CHECK,
        ST_MREAD,
        ST_MDONE,
        ST_EMIT
    } hnm_state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic clr_wr;
        logic wr_child;
        logic wr_node;
        logic char_start;
        logic lookup;
        logic check;
        logic mread;
        logic finish;
        logic emit;
    } hnm_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic [1:0] func;
        logic       clr_done;
        logic       char_skip;
        logic       char_imm;
        logic       go_match;
        logic       finish_emit;
        logic       out_free;
    } hnm_stat_t;

    // Digits, case-folded letters, dot and hyphen; everything else is outside the alphabet.
    function automatic logic [SYM_W-1:0] sym_of(input logic [CHAR_W-1:0] c);
        logic [SYM_W-1:0] s;
        s = SYM_NONE;
        if (c >= "0" && c <= "9") begin
            s = SYM_W'(c - "0");
        end else if (c >= "A" && c <= "Z") begin
            s = SYM_W'(c - "A" + 8'd10);
        end else if (c >= "a" && c <= "z") begin
            s = SYM_W'(c - "a" + 8'd10);
        end else if (c == ".") begin
            s = SYM_DOT;
        end else if (c == "-") begin
            s = SYM_HYPHEN;
        end
        return s;
    endfunction

endpackage

>>> sv/hnm_ram.sv
module hnm_ram #(
    parameter int WIDTH = 12,
    parameter int DEPTH = 4096
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

>>> sv/hnm_ctrl.sv
module hnm_ctrl (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  hnm_pkg::hnm_stat_t stat,
    output hnm_pkg::hnm_cmd_t  cmd
);

    import hnm_pkg::*;

    hnm_state_t state_reg;
    hnm_state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_CLEAR;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        case (state_reg)
            ST_CLEAR: begin
                cmd.clr_wr = 1'b1;
                if (stat.clr_done) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    case (stat.func)
                        FUNC_CHILD: begin
                            cmd.wr_child = 1'b1;
                        end
                        FUNC_NODE: begin
                            cmd.wr_node = 1'b1;
                        end
                        FUNC_CHAR: begin
                            cmd.char_start = 1'b1;
                            if (!stat.char_skip) begin
                                state_next = stat.char_imm ? ST_EMIT : ST_LOOKUP;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_LOOKUP: begin
                cmd.lookup = 1'b1;
                state_next = ST_CHECK;
            end
            ST_CHECK: begin
                cmd.check  = 1'b1;
                state_next = stat.go_match ? ST_MREAD : ST_LOOKUP;
            end
            ST_MREAD: begin
                cmd.mread  = 1'b1;
                state_next = ST_MDONE;
            end
            ST_MDONE: begin
                cmd.finish = 1'b1;
                state_next = stat.finish_emit ? ST_EMIT : ST_IDLE;
            end
            ST_EMIT: begin
                if (stat.out_free) begin
                    cmd.emit   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_CLEAR;
            end
        endcase
    end

endmodule

>>> sv/hnm_dp.sv
module hnm_dp #(
    parameter int NODES = hnm_pkg::NODES_DEF
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       cfg_we,
    input  logic [hnm_pkg::CNT_W-1:0]  cfg_wdata,
    input  hnm_pkg::hnm_in_t           s_data,
    output logic                       m_valid,
    input  logic                       m_ready,
    output hnm_pkg::hnm_out_t          m_data,
    input  hnm_pkg::hnm_cmd_t          cmd,
    output hnm_pkg::hnm_stat_t         stat
);

    import hnm_pkg::*;

    localparam int NW = $clog2(NODES);
    localparam int GD = NODES * ALPHABET;
    localparam int GW = $clog2(GD);
    localparam int SW = $clog2(NODES + 1);

    // A link target outside the node range counts as the root.
    function automatic logic [NW-1:0] follow(input logic [NODE_FW-1:0] v);
        return (32'(v) < NODES) ? NW'(v) : '0;
    endfunction

    logic [GW-1:0]      clr_reg, clr_next;
    logic [NW-1:0]      n_reg, n_next;
    logic [SYM_W-1:0]   s_reg, s_next;
    logic               last_reg, last_next;
    logic [SW-1:0]      steps_reg, steps_next;
    logic [NW-1:0]      cur_reg, cur_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic               decided_reg, decided_next;
    logic [CNT_W-1:0]   max_chars_reg, max_chars_next;
    hnm_out_t           pend_reg, pend_next;
    logic               m_valid_reg, m_valid_next;
    hnm_out_t           m_data_reg, m_data_next;

    logic [NODE_FW-1:0] goto_rd;
    logic [NODE_FW-1:0] fail_rd;
    logic [PID_W-1:0]   match_rd;
    logic               goto_we;
    logic [GW-1:0]      goto_waddr;
    logic [GW-1:0]      goto_raddr;
    logic               match_we;
    logic [NW-1:0]      match_waddr;
    logic [PID_W-1:0]   match_wdata;
    logic               node_ok;
    logic [SYM_W-1:0]   sym_in;
    logic               over_limit;
    logic [NW-1:0]      child_v;
    logic [CNT_W-1:0]   cnt_inc;
    logic               fin_emit;

    assign node_ok    = 32'(s_data.node) < NODES;
    assign sym_in     = sym_of(s_data.char_code);
    assign over_limit = cnt_reg >= max_chars_reg;
    assign child_v    = follow(goto_rd);
    assign cnt_inc    = cnt_reg + CNT_W'(1);
    assign fin_emit   = (match_rd != '0) || last_reg || (cnt_inc >= max_chars_reg);

    // Child links: one row of ALPHABET entries per node.
    assign goto_we    = cmd.clr_wr ||
                        (cmd.wr_child && node_ok && (s_data.symbol < SYM_W'(ALPHABET)));
    assign goto_waddr = cmd.clr_wr ? clr_reg
                        : GW'(s_data.node) * GW'(ALPHABET) + GW'(s_data.symbol);
    assign goto_raddr = GW'(n_reg) * GW'(ALPHABET) + GW'(s_reg);

    assign match_we    = (cmd.clr_wr && (32'(clr_reg) < NODES)) ||
                         (cmd.wr_node && node_ok);
    assign match_waddr = cmd.clr_wr ? NW'(clr_reg) : NW'(s_data.node);
    assign match_wdata = (cmd.clr_wr || (32'(s_data.pattern_id) > PATTERNS))
                         ? '0 : s_data.pattern_id;

    hnm_ram #(.WIDTH(NODE_FW), .DEPTH(GD)) u_goto_ram (
        .aclk    (aclk),
        .wr_en   (goto_we),
        .wr_addr (goto_waddr),
        .wr_data (cmd.clr_wr ? '0 : s_data.child_node),
        .rd_en   (cmd.lookup),
        .rd_addr (goto_raddr),
        .rd_data (goto_rd)
    );

    hnm_ram #(.WIDTH(NODE_FW), .DEPTH(NODES)) u_fail_ram (
        .aclk    (aclk),
        .wr_en   (cmd.wr_node && node_ok),
        .wr_addr (NW'(s_data.node)),
        .wr_data (s_data.fail_node),
        .rd_en   (cmd.lookup),
        .rd_addr (n_reg),
        .rd_data (fail_rd)
    );

    hnm_ram #(.WIDTH(PID_W), .DEPTH(NODES)) u_match_ram (
        .aclk    (aclk),
        .wr_en   (match_we),
        .wr_addr (match_waddr),
        .wr_data (match_wdata),
        .rd_en   (cmd.mread),
        .rd_addr (n_reg),
        .rd_data (match_rd)
    );

    always_comb begin
        clr_next       = clr_reg;
        n_next         = n_reg;
        s_next         = s_reg;
        last_next      = last_reg;
        steps_next     = steps_reg;
        cur_next       = cur_reg;
        cnt_next       = cnt_reg;
        decided_next   = decided_reg;
        max_chars_next = max_chars_reg;
        pend_next      = pend_reg;
        m_valid_next   = m_valid_reg;
        m_data_next    = m_data_reg;

        if (cfg_we) begin
            max_chars_next = cfg_wdata;
        end

        if (cmd.clr_wr) begin
            clr_next = clr_reg + GW'(1);
        end

        if (cmd.char_start) begin
            n_next     = cur_reg;
            s_next     = sym_in;
            last_next  = s_data.last;
            steps_next = '0;
            if (!decided_reg && (over_limit || (sym_in == SYM_NONE))) begin
                pend_next    = '{blocked: 1'b0, hit_pattern: '0, bad_char: !over_limit};
                decided_next = 1'b1;
            end
            if (s_data.last && (decided_reg || over_limit || (sym_in == SYM_NONE))) begin
                cur_next     = '0;
                cnt_next     = '0;
                decided_next = 1'b0;
            end
        end

        // One step of the fail walk, or the step to the child.
        if (cmd.check) begin
            if (child_v != '0) begin
                n_next = child_v;
            end else if (n_reg != '0) begin
                if (steps_reg == SW'(NODES)) begin
                    n_next = '0;
                end else begin
                    n_next     = follow(fail_rd);
                    steps_next = steps_reg + SW'(1);
                end
            end
        end

        if (cmd.finish) begin
            cur_next = n_reg;
            cnt_next = cnt_inc;
            if (fin_emit) begin
                pend_next    = '{blocked: (match_rd != '0), hit_pattern: match_rd,
                                 bad_char: 1'b0};
                decided_next = 1'b1;
            end
            if (last_reg) begin
                cur_next     = '0;
                cnt_next     = '0;
                decided_next = 1'b0;
            end
        end

        if (cmd.emit) begin
            m_valid_next = 1'b1;
            m_data_next  = pend_reg;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_reg       <= '0;
            cur_reg       <= '0;
            cnt_reg       <= '0;
            decided_reg   <= 1'b0;
            max_chars_reg <= MAX_CHARS_RESET;
            m_valid_reg   <= 1'b0;
        end else begin
            clr_reg       <= clr_next;
            cur_reg       <= cur_next;
            cnt_reg       <= cnt_next;
            decided_reg   <= decided_next;
            max_chars_reg <= max_chars_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        n_reg      <= n_next;
        s_reg      <= s_next;
        last_reg   <= last_next;
        steps_reg  <= steps_next;
        pend_reg   <= pend_next;
        m_data_reg <= m_data_next;
    end

    assign stat.func        = s_data.func;
    assign stat.clr_done    = clr_reg == GW'(GD - 1);
    assign stat.char_skip   = decided_reg;
    assign stat.char_imm    = over_limit || (sym_in == SYM_NONE);
    assign stat.go_match    = (child_v != '0) || (n_reg == '0);
    assign stat.finish_emit = fin_emit;
    assign stat.out_free    = !m_valid_reg || m_ready;

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

>>> sv/host_name_multi_pattern_matcher.sv
// Flow: a walking host beat passes through lookup and check (repeated for each fail link
// followed), match read and finish; a bad byte or a byte past the length limit goes to emit.
// Throughput: one table-write beat per cycle while idle; a walking host beat, a bad byte or
// an over-limit byte holds the input until it is done, while a byte of an already decided
// host is taken without leaving idle. A deciding beat also waits while the output is still full.
// Reset: synchronous, active low; then a clearing pass zeroes the child-link and match tables.
module host_name_multi_pattern_matcher #(
    parameter int NODES = hnm_pkg::NODES_DEF
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      cfg_we,
    input  logic [hnm_pkg::CNT_W-1:0] cfg_wdata,
    input  logic                      s_valid,
    output logic                      s_ready,
    input  hnm_pkg::hnm_in_t          s_data,
    output logic                      m_valid,
    input  logic                      m_ready,
    output hnm_pkg::hnm_out_t         m_data
);

    import hnm_pkg::*;

    // The controller sequences each walking host beat through lookup, check (repeated along the
    // fail chain), match read and finish; the datapath holds the three tables, the
    // per-host state and the output register. A finished result waits in the output
    // register while the next beat is taken; only an emit stalls when it is still full.
    hnm_cmd_t  cmd;
    hnm_stat_t stat;

    hnm_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    hnm_dp #(.NODES(NODES)) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cmd       (cmd),
        .stat      (stat)
    );

endmodule

>>> sv/hnm_checker.sv
module hnm_checker (
    input logic                      aclk,
    input logic                      aresetn,
    input logic                      cfg_we,
    input logic [hnm_pkg::CNT_W-1:0] cfg_wdata,
    input logic                      s_valid,
    input logic                      s_ready,
    input hnm_pkg::hnm_in_t          s_data,
    input logic                      m_valid,
    input logic                      m_ready,
    input hnm_pkg::hnm_out_t         m_data
);

    import hnm_pkg::*;

    // A stalled result beat stays offered.
    a_m_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid)
        else $error("result beat dropped while stalled");

    a_m_stable: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> $stable(m_data))
        else $error("result beat changed while stalled");

    // The clearing pass follows every reset, so no beat is taken right after it.
    a_clear_after_reset: assert property (@(posedge aclk)
        !aresetn |=> !s_ready)
        else $error("input taken before the table clear");

    // A table write never brings out a result of its own.
    a_write_no_result: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && (s_data.func != FUNC_CHAR) && !m_valid |=> !m_valid)
        else $error("result after a table write");

    // A match carries its id; a bad character or a miss carries none.
    a_result_coding: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_data.blocked == (m_data.hit_pattern != '0)) &&
                    !(m_data.bad_char && m_data.blocked))
        else $error("inconsistent result fields");

    logic unused_cfg;
    assign unused_cfg = cfg_we ^ (^cfg_wdata);

endmodule

bind host_name_multi_pattern_matcher hnm_checker u_hnm_checker (
    .aclk      (aclk),
    .aresetn   (aresetn),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .s_valid   (s_valid),
    .s_ready   (s_ready),
    .s_data    (s_data),
    .m_valid   (m_valid),
    .m_ready   (m_ready),
    .m_data    (m_data)
);
